### rtl/bitmap_first_free_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap first-free allocator
// Short forms for clocked implications with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define BFFA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define BFFA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the bitmap first-free allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  // Entry numbers, counts and register data all share one width.
  localparam int unsigned NUM_W       = 14;
  localparam int unsigned NUM_MAX     = (2 ** NUM_W) - 1;
  localparam int unsigned WORD_W      = NUM_W - 5;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam int unsigned BFFA_MAP_BITS = 8192;
  localparam logic [NUM_W-1:0] COUNT_RESET = NUM_W'(8192);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic MAP_INODE = 1'b0;
  localparam logic MAP_BLOCK = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_INODE_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_CLEAR = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_FREE_CHK,
    ST_WRITE,
    ST_DONE
  } state_e;

endpackage

### rtl/bitmap_first_free_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// Inode and block allocation bitmaps with first-free search and free checks.
// ----------------------------------------------------------------------------
// Both bitmaps live in one single-port-read, single-port-write RAM of 32-bit
// words, the inode map in the lower half and the block map in the upper half.
// After reset a clearing pass writes zero to every word, one word per cycle;
// the input is stalled during that pass, while configuration writes are taken
// at any time. The block works on one item at a time. An allocate reads the
// chosen map one word per cycle from word 0 until it finds a clear bit below
// the configured count; it reads at most ceil(count/32) words, 256 at the
// default size. A free reads one word, checks the bit and writes it back. A
// finished result waits in an output register, and the next item is accepted
// while it waits.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator
  import bffa_pkg::*;
#(
  parameter int unsigned MAP_BITS = BFFA_MAP_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [NUM_W-1:0]       cfg_wdata_i,
  // Request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   func_i,
  input  logic                   which_map_i,
  input  logic [NUM_W-1:0]       entry_number_i,
  // Result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [NUM_W-1:0]       result_number_o,
  output logic [1:0]             status_o,
  output logic [NUM_W-1:0]       free_count_o
);

  localparam int unsigned MapWords = (MAP_BITS + 31) / 32;
  localparam int unsigned AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned MemDepth = 2 ** (AddrW + 1);
  // Largest count that can be searched; counts above it are clamped.
  localparam logic [NUM_W-1:0] LimitMax =
    (MAP_BITS > NUM_MAX) ? NUM_W'(NUM_MAX) : NUM_W'(MAP_BITS);

  // Bitmap RAM: address is {map select, word index}.
  logic [31:0]    mem_q [MemDepth];
  logic [31:0]    rdata_q;
  logic           mem_we, mem_re;
  logic [AddrW:0] mem_waddr, mem_raddr;
  logic [31:0]    mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Control state
  state_e         state_q, state_d;
  logic [AddrW:0] clr_q, clr_d;
  logic [NUM_W-1:0] inode_count_q, block_count_q;
  logic [NUM_W-1:0] inodes_used_q, inodes_used_d;
  logic [NUM_W-1:0] blocks_used_q, blocks_used_d;
  logic           out_valid_q, out_valid_d;

  // Item payload and working registers
  logic              func_q, func_d;
  logic              sel_q, sel_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [WORD_W-1:0] ptr_q, ptr_d;
  logic [WORD_W-1:0] eval_q, eval_d;
  logic [31:0]       wdata_q, wdata_d;
  logic [NUM_W-1:0]  result_q, result_d;
  status_e           status_q, status_d;
  logic [NUM_W-1:0]  out_result_q, out_result_d;
  status_e           out_status_q, out_status_d;
  logic [NUM_W-1:0]  out_free_q, out_free_d;

  // Derived values for the item in flight
  logic [NUM_W-1:0]  count_sel, limit, limit_m1, used_sel, free_count;
  logic [WORD_W-1:0] last_word;
  logic [31:0]       valid_mask, free_cand;
  logic              found;
  logic [4:0]        pos;
  logic [NUM_W-1:0]  free_idx;
  logic [31:0]       free_mask;
  logic              out_slot;

  assign count_sel = sel_q ? block_count_q : inode_count_q;
  assign limit     = (count_sel > LimitMax) ? LimitMax : count_sel;
  assign limit_m1  = limit - NUM_W'(1);
  assign last_word = limit_m1[NUM_W-1:5];
  assign used_sel  = sel_q ? blocks_used_q : inodes_used_q;
  assign free_count = (limit > used_sel) ? (limit - used_sel) : '0;

  // In the last searchable word, bits at or above the count read as taken.
  assign valid_mask = (eval_q == last_word) ? (32'hFFFF_FFFF >> (5'd31 - limit_m1[4:0]))
                                            : 32'hFFFF_FFFF;
  assign free_cand  = ~rdata_q & valid_mask;

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int j = 31; j >= 0; j--) begin
      if (free_cand[j]) begin
        found = 1'b1;
        pos   = 5'(j);
      end
    end
  end

  assign free_idx  = num_q - NUM_W'(1);
  assign free_mask = 32'd1 << free_idx[4:0];
  assign out_slot  = !out_valid_q || !out_stall_i;

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign result_number_o = out_result_q;
  assign status_o        = out_status_q;
  assign free_count_o    = out_free_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (func_q == FUNC_ALLOC) begin
          state_d = (limit == '0) ? ST_DONE : ST_SCAN;
        end else begin
          state_d = (num_q == '0 || num_q > limit) ? ST_DONE : ST_FREE_CHK;
        end
      end
      ST_SCAN: begin
        if (found) begin
          state_d = ST_WRITE;
        end else if (eval_q == last_word) begin
          state_d = ST_DONE;
        end
      end
      ST_FREE_CHK: begin
        state_d = ((rdata_q & free_mask) == '0) ? ST_DONE : ST_WRITE;
      end
      ST_WRITE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_slot) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Datapath, RAM controls and counters
  always_comb begin
    clr_d         = clr_q;
    inodes_used_d = inodes_used_q;
    blocks_used_d = blocks_used_q;
    out_valid_d   = out_valid_q && out_stall_i;
    func_d        = func_q;
    sel_d         = sel_q;
    num_d         = num_q;
    ptr_d         = ptr_q;
    eval_d        = eval_q;
    wdata_d       = wdata_q;
    result_d      = result_q;
    status_d      = status_q;
    out_result_d  = out_result_q;
    out_status_d  = out_status_q;
    out_free_d    = out_free_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = {sel_q, AddrW'(eval_q)};
    mem_wdata     = wdata_q;
    mem_raddr     = {sel_q, AddrW'(ptr_q)};

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          sel_d  = which_map_i;
          num_d  = entry_number_i;
        end
      end
      ST_DISPATCH: begin
        if (func_q == FUNC_ALLOC) begin
          if (limit == '0) begin
            status_d = STAT_FULL;
            result_d = '0;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = {sel_q, AddrW'(0)};
            eval_d    = '0;
            ptr_d     = WORD_W'(1);
          end
        end else begin
          if (num_q == '0 || num_q > limit) begin
            status_d = STAT_RANGE;
            result_d = '0;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = {sel_q, AddrW'(free_idx[NUM_W-1:5])};
            eval_d    = free_idx[NUM_W-1:5];
          end
        end
      end
      ST_SCAN: begin
        if (found) begin
          wdata_d  = rdata_q | (32'd1 << pos);
          result_d = {eval_q, pos} + NUM_W'(1);
          status_d = STAT_OK;
        end else if (eval_q == last_word) begin
          status_d = STAT_FULL;
          result_d = '0;
        end else begin
          // Keep one word read per cycle while the search goes on.
          mem_re = 1'b1;
          eval_d = ptr_q;
          ptr_d  = ptr_q + 1'b1;
        end
      end
      ST_FREE_CHK: begin
        if ((rdata_q & free_mask) == '0) begin
          status_d = STAT_CLEAR;
          result_d = '0;
        end else begin
          wdata_d  = rdata_q & ~free_mask;
          result_d = num_q;
          status_d = STAT_OK;
        end
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        if (func_q == FUNC_ALLOC) begin
          if (sel_q == MAP_BLOCK) begin
            if (blocks_used_q != NUM_W'(NUM_MAX)) blocks_used_d = blocks_used_q + 1'b1;
          end else begin
            if (inodes_used_q != NUM_W'(NUM_MAX)) inodes_used_d = inodes_used_q + 1'b1;
          end
        end else begin
          if (sel_q == MAP_BLOCK) begin
            if (blocks_used_q != '0) blocks_used_d = blocks_used_q - 1'b1;
          end else begin
            if (inodes_used_q != '0) inodes_used_d = inodes_used_q - 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_slot) begin
          out_valid_d  = 1'b1;
          out_result_d = result_q;
          out_status_d = status_q;
          out_free_d   = free_count;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      inode_count_q <= COUNT_RESET;
      block_count_q <= COUNT_RESET;
      inodes_used_q <= '0;
      blocks_used_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      inodes_used_q <= inodes_used_d;
      blocks_used_q <= blocks_used_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_INODE_COUNT: inode_count_q <= cfg_wdata_i;
          REG_BLOCK_COUNT: block_count_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    sel_q        <= sel_d;
    num_q        <= num_d;
    ptr_q        <= ptr_d;
    eval_q       <= eval_d;
    wdata_q      <= wdata_d;
    result_q     <= result_d;
    status_q     <= status_d;
    out_result_q <= out_result_d;
    out_status_q <= out_status_d;
    out_free_q   <= out_free_d;
  end

endmodule

### rtl/bffa_checker.sv
// ----------------------------------------------------------------------------
// bffa_checker
// Port-level assertions for the bitmap first-free allocator.
// ----------------------------------------------------------------------------
`include "bitmap_first_free_allocator_assert.svh"

module bffa_checker
  import bffa_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   cfg_we_i,
  input logic [CFG_INDEX_W-1:0] cfg_index_i,
  input logic [NUM_W-1:0]       cfg_wdata_i,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   func_i,
  input logic                   which_map_i,
  input logic [NUM_W-1:0]       entry_number_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [NUM_W-1:0]       result_number_o,
  input logic [1:0]             status_o,
  input logic [NUM_W-1:0]       free_count_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A result stays offered until it is taken.
  `BFFA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // A success always carries a nonzero number, a failure always zero.
  `BFFA_ASSERT_IMP(a_ok_nonzero, clk_i, rst_ni, out_valid_o && status_o == STAT_OK, result_number_o != '0, "ok result with number zero")
  `BFFA_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, out_valid_o && status_o != STAT_OK, result_number_o == '0, "failed result with nonzero number")

  // Only one item is in work: an accepted item closes the input.
  `BFFA_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_acc, in_stall_o, "second item taken while busy")

  // A new result is only produced by an item in work.
  `BFFA_ASSERT_IMP(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without an item in work")

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .cfg_index_i     (cfg_index_i),
  .cfg_wdata_i     (cfg_wdata_i),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .func_i          (func_i),
  .which_map_i     (which_map_i),
  .entry_number_i  (entry_number_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .result_number_o (result_number_o),
  .status_o        (status_o),
  .free_count_o    (free_count_o)
);

### tb/bitmap_first_free_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_test
// Self-checking bench for the inode and block first-free bitmap allocator.
// ----------------------------------------------------------------------------
// A tracker object keeps its own copy of both bitmaps, the used counts and the
// two count registers. It works out the reply of every accepted request and
// checks every accepted result against the oldest reply still outstanding.
// A short directed part covers the edge numbers, full maps, out-of-range and
// already-free numbers and a count lowered below use. Random phases follow,
// each with fresh counts, mostly small so that maps fill up and allocates see
// full maps. Both handshake sides idle in short random bursts.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_test;
  import bffa_pkg::*;

  localparam int unsigned CLK_HALF    = 6;
  // An allocate can scan all 256 words of a map and the clearing pass after
  // reset writes all 512 RAM words, so QUIET_LIMIT quiet cycles in a row mean a hang.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned MAP_SLOTS   = BFFA_MAP_BITS;
  localparam int unsigned PHASES      = 12;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    status_e          status;
    logic [NUM_W-1:0] free_left;
  } reply_t;

  // Tracks what the allocator holds and the replies it owes.
  class bitmap_tracker;
    bit               taken [2][MAP_SLOTS];
    logic [NUM_W-1:0] count_reg [2];
    logic [NUM_W-1:0] used_cnt [2];
    reply_t           pending_replies [$];
    int unsigned      mismatches;

    function new();
      count_reg[MAP_INODE] = COUNT_RESET;
      count_reg[MAP_BLOCK] = COUNT_RESET;
      used_cnt[MAP_INODE]  = '0;
      used_cnt[MAP_BLOCK]  = '0;
      mismatches           = 0;
    endfunction

    // Number of bits actually searched in a map.
    function int unsigned searchable(logic sel);
      return (count_reg[sel] < MAP_SLOTS) ? count_reg[sel] : MAP_SLOTS;
    endfunction

    function void set_count(logic [CFG_INDEX_W-1:0] idx, logic [NUM_W-1:0] val);
      if (idx == REG_INODE_COUNT) begin
        count_reg[MAP_INODE] = val;
      end else if (idx == REG_BLOCK_COUNT) begin
        count_reg[MAP_BLOCK] = val;
      end
    endfunction

    // Applies one accepted request and queues the reply it must produce.
    function void take_request(logic f, logic sel, logic [NUM_W-1:0] num);
      int unsigned lim;
      int unsigned slot;
      reply_t      r;
      lim      = searchable(sel);
      r.number = '0;
      r.status = STAT_OK;
      if (f == FUNC_ALLOC) begin
        r.status = STAT_FULL;
        for (slot = 0; slot < lim; slot++) begin
          if (!taken[sel][slot]) begin
            taken[sel][slot] = 1'b1;
            if (used_cnt[sel] != NUM_MAX) used_cnt[sel] = used_cnt[sel] + 1'b1;
            r.number = NUM_W'(slot + 1);
            r.status = STAT_OK;
            break;
          end
        end
      end else if (num == 0 || num > lim) begin
        r.status = STAT_RANGE;
      end else if (!taken[sel][num - 1]) begin
        r.status = STAT_CLEAR;
      end else begin
        taken[sel][num - 1] = 1'b0;
        if (used_cnt[sel] != 0) used_cnt[sel] = used_cnt[sel] - 1'b1;
        r.number = num;
      end
      // The free count saturates at zero when the count is below use.
      r.free_left = (lim > used_cnt[sel]) ? NUM_W'(lim - used_cnt[sel]) : '0;
      pending_replies.push_back(r);
    endfunction

    function void match_response(logic [NUM_W-1:0] num, logic [1:0] st,
                                 logic [NUM_W-1:0] fl);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected result: result_number %0d status %0d free_count %0d",
               num, st, fl);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      if (num !== want.number) begin
        $error("result_number: expected %0d, actual %0d", want.number, num);
        mismatches++;
      end
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        mismatches++;
      end
      if (fl !== want.free_left) begin
        $error("free_count: expected %0d, actual %0d", want.free_left, fl);
        mismatches++;
      end
    endfunction

    // Picks a number that is most likely allocated, so frees mostly succeed.
    // Allocation is first-free, so busy bits gather at the low end.
    function logic [NUM_W-1:0] pick_busy(logic sel);
      int unsigned lim;
      int unsigned span;
      int unsigned tries;
      int unsigned slot;
      lim = searchable(sel);
      if (lim == 0) return NUM_W'($urandom_range(0, 3));
      span = (lim < 512) ? lim : 512;
      slot = 0;
      for (tries = 0; tries < 16; tries++) begin
        slot = $urandom_range(0, span - 1);
        if (taken[sel][slot]) return NUM_W'(slot + 1);
      end
      return NUM_W'(slot + 1);
    endfunction
  endclass

  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             cfg_we_i       = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [NUM_W-1:0] cfg_wdata_i    = '0;
  logic             in_valid_i     = 1'b0;
  logic             in_stall_o;
  logic             func_i         = FUNC_ALLOC;
  logic             which_map_i    = MAP_INODE;
  logic [NUM_W-1:0] entry_number_i = '0;
  logic             out_valid_o;
  logic             out_stall_i    = 1'b0;
  logic [NUM_W-1:0] result_number_o;
  logic [1:0]       status_o;
  logic [NUM_W-1:0] free_count_o;

  bitmap_tracker tracker;
  bit            idle_en      = 1'b1;
  int unsigned   stall_left   = 0;
  int unsigned   quiet_cycles = 0;

  bitmap_first_free_allocator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .which_map_i     (which_map_i),
    .entry_number_i  (entry_number_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_number_o (result_number_o),
    .status_o        (status_o),
    .free_count_o    (free_count_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Every handshake and register write is observed here, at the edge where
  // it takes effect, so the tracker sees events in the block's own order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) tracker.set_count(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) begin
        tracker.take_request(func_i, which_map_i, entry_number_i);
      end
      if (out_valid_o && !out_stall_i) begin
        tracker.match_response(result_number_o, status_o, free_count_o);
      end
    end
  end

  // The result side holds off in random bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Ends the run when neither channel has moved an item for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offers one request and returns at the edge where it is accepted. The
  // valid stays high so the next request can follow without a gap.
  task automatic send_request(logic f, logic sel, logic [NUM_W-1:0] num);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= f;
    which_map_i    <= sel;
    entry_number_i <= num;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops sending and waits until every outstanding reply has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [NUM_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly small counts so that maps fill; now and then zero, the full map
  // or a value past the map size, which must behave like the full map.
  function automatic logic [NUM_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COUNT_RESET;
      2: return NUM_W'($urandom_range(MAP_SLOTS + 1, NUM_MAX));
      3: return NUM_W'($urandom_range(97, MAP_SLOTS - 1));
      default: return NUM_W'($urandom_range(1, 96));
    endcase
  endfunction

  // Random traffic: allocates and frees of busy entries dominate, with some
  // frees of arbitrary numbers that land out of range or on free bits.
  task automatic run_phase(int unsigned items);
    int unsigned      roll;
    logic             sel;
    logic [NUM_W-1:0] num;
    for (int unsigned k = 0; k < items; k++) begin
      sel  = $urandom_range(0, 1);
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        send_request(FUNC_ALLOC, sel, NUM_W'($urandom_range(0, NUM_MAX)));
      end else if (roll < 85) begin
        send_request(FUNC_FREE, sel, tracker.pick_busy(sel));
      end else begin
        num = (roll < 93) ? NUM_W'($urandom_range(0, NUM_MAX))
                          : NUM_W'(tracker.searchable(sel) + $urandom_range(0, 2));
        send_request(FUNC_FREE, sel, num);
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Edge numbers at the reset counts: free on an empty map, zero, the largest
    // field value and one past the map are rejected; allocates and frees follow.
    send_request(FUNC_FREE,  MAP_INODE, NUM_W'(1));
    send_request(FUNC_FREE,  MAP_INODE, '0);
    send_request(FUNC_FREE,  MAP_BLOCK, NUM_W'(NUM_MAX));
    send_request(FUNC_FREE,  MAP_BLOCK, NUM_W'(MAP_SLOTS + 1));
    send_request(FUNC_ALLOC, MAP_INODE, NUM_W'(NUM_MAX));
    send_request(FUNC_ALLOC, MAP_BLOCK, '0);
    send_request(FUNC_ALLOC, MAP_INODE, '0);
    send_request(FUNC_FREE,  MAP_INODE, NUM_W'(1));
    send_request(FUNC_ALLOC, MAP_INODE, '0);
    send_request(FUNC_FREE,  MAP_BLOCK, NUM_W'(MAP_SLOTS));
    send_request(FUNC_FREE,  MAP_BLOCK, NUM_W'(1));

    // A zero count makes the inode map full and every number out of range;
    // a block count of three fills after three allocates.
    wait_drained();
    write_reg(REG_INODE_COUNT, '0);
    write_reg(REG_BLOCK_COUNT, NUM_W'(3));
    send_request(FUNC_ALLOC, MAP_INODE, '0);
    send_request(FUNC_FREE,  MAP_INODE, NUM_W'(1));
    repeat (4) send_request(FUNC_ALLOC, MAP_BLOCK, '0);
    send_request(FUNC_FREE,  MAP_BLOCK, NUM_W'(4));
    send_request(FUNC_FREE,  MAP_BLOCK, NUM_W'(3));

    // At a count of two both inodes are already taken, so the allocate finds the map full.
    wait_drained();
    write_reg(REG_INODE_COUNT, NUM_W'(2));
    send_request(FUNC_ALLOC, MAP_INODE, '0);

    // Two inodes are in use; lowering the count to one leaves a set bit
    // outside the searched range and the free count pinned at zero.
    wait_drained();
    write_reg(REG_INODE_COUNT, NUM_W'(1));
    send_request(FUNC_ALLOC, MAP_INODE, '0);
    send_request(FUNC_FREE,  MAP_INODE, NUM_W'(2));
    send_request(FUNC_FREE,  MAP_INODE, NUM_W'(1));

    wait_drained();
    write_reg(REG_INODE_COUNT, NUM_W'(NUM_MAX));
    write_reg(REG_BLOCK_COUNT, COUNT_RESET);
    send_request(FUNC_ALLOC, MAP_INODE, '0);

    // Random phases. The maps keep their contents across phases, so a new,
    // smaller count often lands below what is already in use. Each phase
    // starts only after all replies of the previous one have come back.
    for (int unsigned p = 0; p < PHASES; p++) begin
      wait_drained();
      write_reg(REG_INODE_COUNT, pick_count());
      write_reg(REG_BLOCK_COUNT, pick_count());
      idle_en = (p + 2 < PHASES) ? ($urandom_range(0, 3) != 0) : 1'b0;
      run_phase(100 + $urandom_range(0, 20));
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
